// ===== src/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared constants, command, status and radix codes, sequencer states and divider types.
// ----------------------------------------------------------------------------
`default_nettype none
package rpn_pkg;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CntW = $clog2(StackDepth + 1);
  localparam int unsigned DataW = 32;

  typedef enum logic [4:0] {
    CmdPush = 5'd0, CmdAdd = 5'd1, CmdSub = 5'd2, CmdMul = 5'd3, CmdDiv = 5'd4,
    CmdMod = 5'd5, CmdXor = 5'd6, CmdAnd = 5'd7, CmdOr = 5'd8, CmdGetIn = 5'd9,
    CmdGetOut = 5'd10, CmdGetDbg = 5'd11, CmdSetIn = 5'd12, CmdSetOut = 5'd13,
    CmdSetDbg = 5'd14, CmdClear = 5'd15, CmdDup = 5'd16, CmdPeek = 5'd17,
    CmdPop = 5'd18, CmdPrintAll = 5'd19, CmdSwap = 5'd20, CmdNot = 5'd21,
    CmdInvert = 5'd22
  } cmd_e;

  typedef enum logic [2:0] {
    StOk = 3'd0, StUnder = 3'd1, StOver = 3'd2, StDivZero = 3'd3, StBadRadix = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RadixDec = 2'd0, RadixHex = 2'd1, RadixOct = 2'd2
  } radix_e;

  typedef enum logic [3:0] {
    SIdle, SRdA, SRdB, SWaitB, SExec, SDiv, SWrite, SWrite2, SWalk, SWalkOut, SOut
  } state_e;

  typedef struct packed {
    logic       start;
    logic       is_mod;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [DataW-1:0] result;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== src/rpn_if.sv =====
// ----------------------------------------------------------------------------
// RPN channel interfaces
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface rpn_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  req_type;
  logic signed [31:0] push_value;
  modport source (output valid, req_type, push_value, input ready);
  modport sink (input valid, req_type, push_value, output ready);
endinterface

interface rpn_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_value;
  logic        has_value;
  logic [1:0]  radix_code;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, out_value, has_value, radix_code, status, last,
                  input ready);
  modport sink (input valid, out_value, has_value, radix_code, status, last,
                output ready);
endinterface
`default_nettype wire

// ===== src/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/rpn_div.sv =====
// ----------------------------------------------------------------------------
// RPN divider
// Signed radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rpn_pkg::div_req_t req_i,
  output rpn_pkg::div_rsp_t     rsp_o
);
  localparam int unsigned W = rpn_pkg::DataW;

  logic             busy_q, busy_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic             qneg_q, qneg_d, rneg_q, rneg_d, mod_q, mod_d;
  logic             done_q, done_d;
  logic [W:0]       trial;
  logic [W-1:0]     shrem;
  logic [W-1:0]     q_fix, r_fix;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    qneg_d = qneg_q;
    rneg_d = rneg_q;
    mod_d  = mod_q;
    done_d = 1'b0;
    shrem  = {rem_q[W-2:0], quo_q[W-1]};
    trial  = {1'b0, shrem} - {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = req_i.a[W-1] ? -req_i.a : req_i.a;
      dvs_d  = req_i.b[W-1] ? -req_i.b : req_i.b;
      rem_d  = '0;
      qneg_d = req_i.a[W-1] ^ req_i.b[W-1];
      rneg_d = req_i.a[W-1];
      mod_d  = req_i.is_mod;
    end else if (busy_q) begin
      if (trial[W]) begin
        rem_d = shrem;
        quo_d = {quo_q[W-2:0], 1'b0};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
    mod_q  <= mod_d;
  end

  assign q_fix = qneg_q ? -quo_q : quo_q;
  assign r_fix = rneg_q ? -rem_q : rem_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = mod_q ? r_fix : q_fix;
endmodule
`default_nettype wire

// ===== src/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// RPN ALU
// Combinational add, subtract, multiply, logic and unary operations.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_alu (
  input  wire logic [4:0]  cmd_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] res_o
);
  always_comb begin
    case (cmd_i)
      rpn_pkg::CmdAdd:    res_o = a_i + b_i;
      rpn_pkg::CmdSub:    res_o = a_i - b_i;
      rpn_pkg::CmdMul:    res_o = a_i * b_i;
      rpn_pkg::CmdXor:    res_o = a_i ^ b_i;
      rpn_pkg::CmdAnd:    res_o = a_i & b_i;
      rpn_pkg::CmdOr:     res_o = a_i | b_i;
      rpn_pkg::CmdNot:    res_o = {31'd0, a_i == 32'd0};
      rpn_pkg::CmdInvert: res_o = ~a_i;
      default:            res_o = a_i;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// RPN stack calculator
// Command-driven 32-bit integer operand stack with a shared divider.
// Print-all reads the stack elements one at a time through the single RAM read port.
// One command at a time; ready is low until the last result is taken.
// Reset clears the count, input radix and debug registers and sets the output radix to 10;
// stack RAM is not cleared.
`default_nettype none
module rpn_stack_calculator (
  input wire logic clk_i,
  input wire logic rst_ni,
  rpn_req_if.sink   req_i,
  rpn_rsp_if.source rsp_o
);
  localparam int unsigned AW = rpn_pkg::AddrW;
  localparam int unsigned CW = rpn_pkg::CntW;
  localparam logic [CW-1:0] Full = CW'(rpn_pkg::StackDepth);

  rpn_pkg::state_e state_q, state_d;
  logic [4:0]    cmd_q;
  logic [31:0]   pv_q, a_q, b_q, wdat_q;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [31:0]   inrad_q, outrad_q, dbg_q;
  logic          ovalid_q;
  logic [31:0]   oval_q;
  logic          ohas_q, olast_q;
  logic [1:0]    orad_q;
  logic [2:0]    ost_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata, alu_res;
  logic          rad_ok;
  logic [1:0]    rad_code;
  rpn_pkg::div_req_t div_req;
  rpn_pkg::div_rsp_t div_rsp;
  logic          accept, take;
  logic [2:0]    err;
  logic          emit, emit_has, emit_last;
  logic [31:0]   emit_val;
  logic [2:0]    emit_st;

  assign accept = req_i.valid && req_i.ready;
  assign take   = rsp_o.valid && rsp_o.ready;
  assign req_i.ready = (state_q == rpn_pkg::SIdle) && !ovalid_q;

  rpn_ram #(.Width(32), .Depth(rpn_pkg::StackDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  rpn_alu u_alu (.cmd_i(cmd_q), .a_i(a_q), .b_i(b_q), .res_o(alu_res));

  rpn_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  always_comb begin
    rad_ok = 1'b1;
    rad_code = rpn_pkg::RadixDec;
    if (outrad_q == 32'd16) rad_code = rpn_pkg::RadixHex;
    else if (outrad_q == 32'd8) rad_code = rpn_pkg::RadixOct;
    else if (outrad_q != 32'd10) rad_ok = 1'b0;
  end

  always_comb begin
    err = rpn_pkg::StOk;
    case (req_i.req_type)
      rpn_pkg::CmdPush, rpn_pkg::CmdGetIn, rpn_pkg::CmdGetOut, rpn_pkg::CmdGetDbg:
        if (cnt_q >= Full) err = rpn_pkg::StOver;
      rpn_pkg::CmdAdd, rpn_pkg::CmdSub, rpn_pkg::CmdMul, rpn_pkg::CmdDiv,
      rpn_pkg::CmdMod, rpn_pkg::CmdXor, rpn_pkg::CmdAnd, rpn_pkg::CmdOr,
      rpn_pkg::CmdSwap:
        if (cnt_q < CW'(2)) err = rpn_pkg::StUnder;
      rpn_pkg::CmdSetIn, rpn_pkg::CmdSetOut, rpn_pkg::CmdSetDbg,
      rpn_pkg::CmdNot, rpn_pkg::CmdInvert:
        if (cnt_q == '0) err = rpn_pkg::StUnder;
      rpn_pkg::CmdDup:
        if (cnt_q == '0) err = rpn_pkg::StUnder;
        else if (cnt_q >= Full) err = rpn_pkg::StOver;
      rpn_pkg::CmdPeek, rpn_pkg::CmdPop:
        if (cnt_q == '0) err = rpn_pkg::StUnder;
        else if (!rad_ok) err = rpn_pkg::StBadRadix;
      rpn_pkg::CmdPrintAll:
        if (!rad_ok) err = rpn_pkg::StBadRadix;
      default: err = rpn_pkg::StOk;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rpn_pkg::SIdle:
        if (accept) begin
          if (err != rpn_pkg::StOk) state_d = rpn_pkg::SIdle;
          else begin
            case (req_i.req_type)
              rpn_pkg::CmdPush, rpn_pkg::CmdGetIn, rpn_pkg::CmdGetOut,
              rpn_pkg::CmdGetDbg, rpn_pkg::CmdClear: state_d = rpn_pkg::SWrite;
              rpn_pkg::CmdPrintAll:
                state_d = (cnt_q == '0) ? rpn_pkg::SIdle : rpn_pkg::SWalk;
              rpn_pkg::CmdAdd, rpn_pkg::CmdSub, rpn_pkg::CmdMul, rpn_pkg::CmdDiv,
              rpn_pkg::CmdMod, rpn_pkg::CmdXor, rpn_pkg::CmdAnd, rpn_pkg::CmdOr,
              rpn_pkg::CmdSwap, rpn_pkg::CmdSetIn, rpn_pkg::CmdSetOut,
              rpn_pkg::CmdSetDbg, rpn_pkg::CmdDup, rpn_pkg::CmdPeek, rpn_pkg::CmdPop,
              rpn_pkg::CmdNot, rpn_pkg::CmdInvert: state_d = rpn_pkg::SRdA;
              default: state_d = rpn_pkg::SIdle;
            endcase
          end
        end
      rpn_pkg::SRdA: state_d = rpn_pkg::SRdB;
      rpn_pkg::SRdB: state_d = rpn_pkg::SWaitB;
      rpn_pkg::SWaitB: state_d = rpn_pkg::SExec;
      rpn_pkg::SExec: begin
        if ((cmd_q == rpn_pkg::CmdDiv || cmd_q == rpn_pkg::CmdMod)
            && b_q != 32'd0) state_d = rpn_pkg::SDiv;
        else if (cmd_q == rpn_pkg::CmdDiv || cmd_q == rpn_pkg::CmdMod
                 || cmd_q == rpn_pkg::CmdPeek || cmd_q == rpn_pkg::CmdPop)
          state_d = rpn_pkg::SOut;
        else state_d = rpn_pkg::SWrite;
      end
      rpn_pkg::SDiv: if (div_rsp.done) state_d = rpn_pkg::SWrite;
      rpn_pkg::SWrite:
        state_d = (cmd_q == rpn_pkg::CmdSwap) ? rpn_pkg::SWrite2 : rpn_pkg::SOut;
      rpn_pkg::SWrite2: state_d = rpn_pkg::SOut;
      rpn_pkg::SWalk: state_d = rpn_pkg::SWalkOut;
      rpn_pkg::SWalkOut:
        if (!ovalid_q || take) begin
          state_d = (idx_q + CW'(1) >= cnt_q) ? rpn_pkg::SIdle : rpn_pkg::SWalk;
        end
      rpn_pkg::SOut: if (!ovalid_q || take) state_d = rpn_pkg::SIdle;
      default: state_d = rpn_pkg::SIdle;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = cnt_q[AW-1:0];
    wdata = wdat_q;
    raddr = '0;
    cnt_d = cnt_q;
    idx_d = idx_q;
    div_req = '0;
    div_req.a = a_q;
    div_req.b = b_q;
    div_req.is_mod = (cmd_q == rpn_pkg::CmdMod);
    case (state_q)
      rpn_pkg::SIdle: idx_d = '0;
      rpn_pkg::SRdA: raddr = AW'(cnt_q - CW'(1));
      rpn_pkg::SRdB: raddr = AW'(cnt_q - CW'(2));
      rpn_pkg::SExec: div_req.start = (state_d == rpn_pkg::SDiv);
      rpn_pkg::SWrite: begin
        case (cmd_q)
          rpn_pkg::CmdClear: cnt_d = '0;
          rpn_pkg::CmdSetIn, rpn_pkg::CmdSetOut, rpn_pkg::CmdSetDbg:
            cnt_d = cnt_q - CW'(1);
          rpn_pkg::CmdPush, rpn_pkg::CmdGetIn, rpn_pkg::CmdGetOut, rpn_pkg::CmdGetDbg,
          rpn_pkg::CmdDup: begin
            we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end
          rpn_pkg::CmdNot, rpn_pkg::CmdInvert, rpn_pkg::CmdSwap: begin
            we = 1'b1;
            waddr = AW'(cnt_q - CW'(1));
          end
          rpn_pkg::CmdDiv, rpn_pkg::CmdMod: begin
            we = 1'b1;
            waddr = AW'(cnt_q - CW'(2));
            wdata = div_rsp.result;
            cnt_d = cnt_q - CW'(1);
          end
          default: begin
            we = 1'b1;
            waddr = AW'(cnt_q - CW'(2));
            cnt_d = cnt_q - CW'(1);
          end
        endcase
      end
      rpn_pkg::SWrite2: begin
        we = 1'b1;
        waddr = AW'(cnt_q - CW'(2));
        wdata = a_q;
      end
      rpn_pkg::SWalk: raddr = idx_q[AW-1:0];
      rpn_pkg::SWalkOut: begin
        raddr = idx_q[AW-1:0];
        if (!ovalid_q || take) idx_d = idx_q + CW'(1);
      end
      rpn_pkg::SOut:
        if ((!ovalid_q || take) && cmd_q == rpn_pkg::CmdPop) cnt_d = cnt_q - CW'(1);
      default: ;
    endcase
  end

  always_comb begin
    emit = 1'b0;
    emit_val = '0;
    emit_has = 1'b0;
    emit_last = 1'b1;
    emit_st = rpn_pkg::StOk;
    case (state_q)
      rpn_pkg::SIdle: begin
        emit = accept && (err != rpn_pkg::StOk || state_d == rpn_pkg::SIdle);
        emit_st = err;
      end
      rpn_pkg::SWalkOut: begin
        emit = !ovalid_q || take;
        emit_val = rdata;
        emit_has = 1'b1;
        emit_last = (idx_q + CW'(1) >= cnt_q);
      end
      rpn_pkg::SOut: begin
        emit = !ovalid_q || take;
        if (cmd_q == rpn_pkg::CmdPeek || cmd_q == rpn_pkg::CmdPop) begin
          emit_val = a_q;
          emit_has = 1'b1;
        end else if ((cmd_q == rpn_pkg::CmdDiv || cmd_q == rpn_pkg::CmdMod)
                     && b_q == 32'd0) begin
          emit_st = rpn_pkg::StDivZero;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rpn_pkg::SIdle;
      cnt_q    <= '0;
      idx_q    <= '0;
      inrad_q  <= '0;
      outrad_q <= 32'd10;
      dbg_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (state_q == rpn_pkg::SWrite) begin
        case (cmd_q)
          rpn_pkg::CmdSetIn:  inrad_q  <= a_q;
          rpn_pkg::CmdSetOut: outrad_q <= a_q;
          rpn_pkg::CmdSetDbg: dbg_q    <= a_q;
          default: ;
        endcase
      end
      if (emit) ovalid_q <= 1'b1;
      else if (take) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.req_type;
      pv_q  <= req_i.push_value;
    end
    if (state_q == rpn_pkg::SRdB) a_q <= rdata;
    if (state_q == rpn_pkg::SWaitB) b_q <= rdata;
    if (state_q == rpn_pkg::SExec) begin
      case (cmd_q)
        rpn_pkg::CmdPush:   wdat_q <= pv_q;
        rpn_pkg::CmdGetIn:  wdat_q <= inrad_q;
        rpn_pkg::CmdGetOut: wdat_q <= outrad_q;
        rpn_pkg::CmdGetDbg: wdat_q <= dbg_q;
        rpn_pkg::CmdSwap:   wdat_q <= b_q;
        default:            wdat_q <= alu_res;
      endcase
    end else if (accept) begin
      case (req_i.req_type)
        rpn_pkg::CmdGetIn:  wdat_q <= inrad_q;
        rpn_pkg::CmdGetOut: wdat_q <= outrad_q;
        rpn_pkg::CmdGetDbg: wdat_q <= dbg_q;
        default:            wdat_q <= req_i.push_value;
      endcase
    end
    if (emit) begin
      oval_q  <= emit_val;
      ohas_q  <= emit_has;
      orad_q  <= emit_has ? rad_code : rpn_pkg::RadixDec;
      ost_q   <= emit_st;
      olast_q <= emit_last;
    end
  end

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.out_value  = oval_q;
  assign rsp_o.has_value  = ohas_q;
  assign rsp_o.radix_code = orad_q;
  assign rsp_o.status     = ost_q;
  assign rsp_o.last       = olast_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("stack count exceeds depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rpn_pkg::SIdle) |-> !req_i.ready) else $error("ready while busy");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == rpn_pkg::SDiv) else $error("stray divider done");
endmodule
`default_nettype wire
